>>> rtl/stmd_pkg.sv
package stmd_pkg;

  localparam int DEF_MAX_TEXT     = 32;
  localparam int DEF_MAX_DISPLAYS = 4;
  localparam int GLYPH_COLUMNS    = 8;
  localparam int GLYPH_BITS       = 3;
  localparam int FONT_DEPTH       = 2048;
  localparam int FONT_AW          = 11;
  localparam int COL_W            = 8;

  localparam logic [15:0] CMD_ON     = 16'h0C01;
  localparam logic [15:0] CMD_OFF    = 16'h0C00;
  localparam logic [7:0]  SPACE_CODE = 8'h20;

  localparam logic [1:0] DIR_STATIC = 2'd0;
  localparam logic [1:0] DIR_DEC    = 2'd1;
  localparam logic [1:0] DIR_INC    = 2'd2;

  localparam logic [1:0] REG_MSG_LEN   = 2'd0;
  localparam logic [1:0] REG_DISP_CNT  = 2'd1;
  localparam logic [1:0] REG_SCROLL    = 2'd2;
  localparam logic [1:0] REG_BLINK     = 2'd3;

  typedef enum logic [2:0] {
    REQ_LOAD_CHAR = 3'd0,
    REQ_LOAD_FONT = 3'd1,
    REQ_SCROLL    = 3'd2,
    REQ_BLINK     = 3'd3,
    REQ_RESTART   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_DISP,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] slot;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] command_word;
    logic        latch_after;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    req_e        op;
    logic [10:0] slot;
    logic [7:0]  byte_value;
  } op_t;

  typedef struct packed {
    logic [5:0] msg_len;
    logic [2:0] disp_cnt;
    logic [1:0] scroll_dir;
    logic       blink_en;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       ready;
  } qhs_t;

  typedef struct packed {
    logic       use_font;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       latch;
    logic       last;
  } meta_t;

endpackage

>>> rtl/stmd_front.sv
module stmd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  stmd_pkg::in_item_t item_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output stmd_pkg::op_t      q_op_o
);

  stmd_pkg::op_t queue_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          known;
  logic          push, pop;

  always_comb begin
    unique case (item_i.req_type) inside
      stmd_pkg::REQ_LOAD_CHAR, stmd_pkg::REQ_LOAD_FONT, stmd_pkg::REQ_SCROLL,
      stmd_pkg::REQ_BLINK, stmd_pkg::REQ_RESTART: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign busy      = (count_q == 2'd2);
  assign push      = start && !busy && known;
  assign q_valid_o = (count_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_op_o    = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q].op         <= stmd_pkg::req_e'(item_i.req_type);
      queue_q[wr_ptr_q].slot       <= item_i.slot;
      queue_q[wr_ptr_q].byte_value <= item_i.byte_value;
    end
  end

endmodule

>>> rtl/stmd_back.sv
module stmd_back #(
  parameter int MAX_TEXT     = stmd_pkg::DEF_MAX_TEXT,
  parameter int MAX_DISPLAYS = stmd_pkg::DEF_MAX_DISPLAYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stmd_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  stmd_pkg::op_t       q_op_i,
  output logic                result_valid_o,
  output stmd_pkg::out_item_t result_o
);

  localparam int MSG_AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int DW     = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;

  stmd_pkg::state_e state_q, state_d;
  logic [2:0]       row_q, row_d;
  logic [DW-1:0]    disp_q, disp_d;
  logic [7:0]       pos_q, pos_d;
  logic             don_q, don_d;
  logic             rst_q, rst_d;

  logic [3:0]       eff_d;
  logic [5:0]       lsat;
  logic [5:0]       eff_len;
  logic [8:0]       len8;
  logic [7:0]       last_col;
  logic             row_last, disp_last, frame_end, disp_follow;

  logic             msg_we, font_we;
  logic             iss_v;
  stmd_pkg::meta_t  iss_meta;
  logic [8:0]       diff;
  logic [7:0]       iss_col;

  logic [7:0]       msg_mem [MAX_TEXT];
  logic [7:0]       font_mem [stmd_pkg::FONT_DEPTH];

  logic             s1_v_q, s2_v_q, s3_v_q;
  stmd_pkg::meta_t  s1_meta_q, s2_meta_q, s3_meta_q;
  logic [7:0]       s1_col_q;
  logic [2:0]       s2_low_q;
  logic             s2_inr_q;
  logic [7:0]       msg_rd_q;
  logic [7:0]       font_rd_q;
  logic [7:0]       code;
  logic [stmd_pkg::FONT_AW-1:0] font_addr;

  always_comb begin
    if (cfg_i.disp_cnt == 3'd0) begin
      eff_d = 4'd1;
    end else if ({1'b0, cfg_i.disp_cnt} > 4'(MAX_DISPLAYS)) begin
      eff_d = 4'(MAX_DISPLAYS);
    end else begin
      eff_d = {1'b0, cfg_i.disp_cnt};
    end
    lsat     = (cfg_i.msg_len > 6'(MAX_TEXT)) ? 6'(MAX_TEXT) : cfg_i.msg_len;
    eff_len  = (lsat < {2'b00, eff_d}) ? {2'b00, eff_d} : lsat;
    len8     = {eff_len, 3'b000};
    last_col = 8'(len8 - 9'd1);
  end

  assign row_last    = (row_q == 3'(stmd_pkg::GLYPH_COLUMNS - 1));
  assign disp_last   = (4'(disp_q) == (eff_d - 4'd1));
  assign frame_end   = row_last && disp_last;
  assign disp_follow = rst_q && !cfg_i.blink_en;

  always_comb begin
    diff    = {1'b0, pos_q} - 9'({disp_q, row_q});
    iss_col = diff[8] ? (diff[7:0] + len8[7:0]) : diff[7:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stmd_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          case (q_op_i.op)
            stmd_pkg::REQ_SCROLL, stmd_pkg::REQ_RESTART: state_d = stmd_pkg::ST_FRAME;
            stmd_pkg::REQ_BLINK: state_d = stmd_pkg::ST_DISP;
            default: state_d = stmd_pkg::ST_IDLE;
          endcase
        end
      end
      stmd_pkg::ST_FRAME: begin
        if (frame_end) begin
          state_d = disp_follow ? stmd_pkg::ST_DISP : stmd_pkg::ST_DRAIN;
        end
      end
      stmd_pkg::ST_DISP: begin
        if (disp_last) begin
          state_d = stmd_pkg::ST_DRAIN;
        end
      end
      stmd_pkg::ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = stmd_pkg::ST_IDLE;
        end
      end
      default: state_d = stmd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    msg_we    = 1'b0;
    font_we   = 1'b0;
    iss_v     = 1'b0;
    iss_meta  = '0;
    row_d     = row_q;
    disp_d    = disp_q;
    pos_d     = pos_q;
    don_d     = don_q;
    rst_d     = rst_q;
    unique case (state_q)
      stmd_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        row_d     = '0;
        disp_d    = '0;
        if (q_valid_i) begin
          case (q_op_i.op)
            stmd_pkg::REQ_LOAD_CHAR: msg_we = (q_op_i.slot < 11'(MAX_TEXT));
            stmd_pkg::REQ_LOAD_FONT: font_we = 1'b1;
            stmd_pkg::REQ_SCROLL:    rst_d = 1'b0;
            stmd_pkg::REQ_BLINK:     don_d = ~don_q;
            stmd_pkg::REQ_RESTART: begin
              pos_d = last_col;
              rst_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      stmd_pkg::ST_FRAME: begin
        iss_v             = 1'b1;
        iss_meta.use_font = 1'b1;
        iss_meta.hi       = 8'(stmd_pkg::GLYPH_COLUMNS) - {5'b00000, row_q};
        iss_meta.latch    = disp_last;
        iss_meta.last     = frame_end && !disp_follow;
        if (disp_last) begin
          disp_d = '0;
          row_d  = row_q + 3'd1;
          if (row_last) begin
            if (cfg_i.scroll_dir == stmd_pkg::DIR_DEC) begin
              pos_d = (pos_q == 8'd0) ? last_col : pos_q - 8'd1;
            end else if (cfg_i.scroll_dir == stmd_pkg::DIR_INC) begin
              pos_d = (pos_q >= last_col) ? 8'd0 : pos_q + 8'd1;
            end
            if (disp_follow) begin
              don_d = 1'b1;
            end
          end
        end else begin
          disp_d = disp_q + 1'b1;
        end
      end
      stmd_pkg::ST_DISP: begin
        iss_v          = 1'b1;
        iss_meta.hi    = stmd_pkg::CMD_ON[15:8];
        iss_meta.lo    = don_q ? stmd_pkg::CMD_ON[7:0] : stmd_pkg::CMD_OFF[7:0];
        iss_meta.latch = disp_last;
        iss_meta.last  = disp_last;
        disp_d         = disp_q + 1'b1;
      end
      stmd_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stmd_pkg::ST_IDLE;
      row_q   <= '0;
      disp_q  <= '0;
      pos_q   <= '0;
      don_q   <= 1'b0;
      rst_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      disp_q  <= disp_d;
      pos_q   <= pos_d;
      don_q   <= don_d;
      rst_q   <= rst_d;
      s1_v_q  <= iss_v;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_meta_q <= iss_meta;
    s1_col_q  <= iss_col;
    s2_meta_q <= s1_meta_q;
    s2_low_q  <= s1_col_q[2:0];
    s2_inr_q  <= ({1'b0, s1_col_q[7:3]} < lsat);
    s3_meta_q <= s2_meta_q;
  end

  always_ff @(posedge clk_i) begin
    if (msg_we) begin
      msg_mem[q_op_i.slot[MSG_AW-1:0]] <= q_op_i.byte_value;
    end
    msg_rd_q <= msg_mem[s1_col_q[3+MSG_AW-1:3]];
  end

  assign code      = s2_inr_q ? msg_rd_q : stmd_pkg::SPACE_CODE;
  assign font_addr = {code, s2_low_q};

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[q_op_i.slot] <= q_op_i.byte_value;
    end
    font_rd_q <= font_mem[font_addr];
  end

  assign result_valid_o        = s3_v_q;
  assign result_o.command_word = {s3_meta_q.hi, s3_meta_q.use_font ? font_rd_q : s3_meta_q.lo};
  assign result_o.latch_after  = s3_meta_q.latch;
  assign result_o.last_word    = s3_meta_q.last;

endmodule

>>> rtl/scrolling_text_matrix_driver.sv
// With an idle back end the first word of an accepted item passes the queue, the back-end
// state register and the s1, s2 and s3 registers; the words of an item follow on consecutive
// cycles. A load item issues no word, a scroll tick eight per display, a blink tick one per
// display, a restart nine (eight with blinking on); the back end drains after each such item.
// A two-entry queue accepts items while the back end works; the receiver cannot stall.
// Reset clears the queue, registers, position and display state; the stores are undefined.
module scrolling_text_matrix_driver #(
  parameter int MAX_TEXT     = stmd_pkg::DEF_MAX_TEXT,
  parameter int MAX_DISPLAYS = stmd_pkg::DEF_MAX_DISPLAYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  stmd_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output stmd_pkg::out_item_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  stmd_pkg::cfg_t cfg_q, cfg_d;
  logic           cfg_we;
  logic           q_valid;
  logic           q_ready;
  stmd_pkg::op_t  q_op;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        stmd_pkg::REG_MSG_LEN:  cfg_d.msg_len    = pwdata[5:0];
        stmd_pkg::REG_DISP_CNT: cfg_d.disp_cnt   = pwdata[2:0];
        stmd_pkg::REG_SCROLL:   cfg_d.scroll_dir = pwdata[1:0];
        stmd_pkg::REG_BLINK:    cfg_d.blink_en   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      stmd_pkg::REG_MSG_LEN:  prdata = {26'd0, cfg_q.msg_len};
      stmd_pkg::REG_DISP_CNT: prdata = {29'd0, cfg_q.disp_cnt};
      stmd_pkg::REG_SCROLL:   prdata = {30'd0, cfg_q.scroll_dir};
      stmd_pkg::REG_BLINK:    prdata = {31'd0, cfg_q.blink_en};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msg_len    <= 6'd0;
      cfg_q.disp_cnt   <= 3'd1;
      cfg_q.scroll_dir <= stmd_pkg::DIR_STATIC;
      cfg_q.blink_en   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  stmd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_op_o    (q_op)
  );

  stmd_back #(
    .MAX_TEXT     (MAX_TEXT),
    .MAX_DISPLAYS (MAX_DISPLAYS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_op_i         (q_op),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
